[src/swtg_pkg.sv]
// swtg_pkg: widths, command codes and scaling constants for the square-wave
// tone generator. No dependencies; every other file takes names from here.
`timescale 1ns / 1ps
`default_nettype none

package swtg_pkg;

  localparam int CMD_W     = 1;
  localparam int COUNT_W   = 16;
  localparam int AMP_W     = 8;
  localparam int DUR_W     = 16;
  localparam int SAMPLE_W  = 8;
  localparam int HP_W      = 27;
  localparam int ELAPSED_W = 32;
  localparam int EDGE_W    = 48;

  localparam int BUFFER_SAMPLES_DEF = 370;
  localparam int FRACTION_BITS_DEF  = 16;

  localparam logic [CMD_W-1:0] CMD_LOAD = 1'b0;
  localparam logic [CMD_W-1:0] CMD_TICK = 1'b1;

  localparam logic [COUNT_W-1:0]  MIN_COUNT = 16'd36;
  localparam logic [SAMPLE_W-1:0] MIDPOINT  = 8'd128;

  // 2^F * 10^7 / (4493 * 78336) reduces to 2^(F-2) * 78125 / 687429
  localparam int SCALE_CORE = 78125;
  localparam int DIV_CORE   = 687429;
  localparam int DIV_W      = 20;
  localparam int SCALE_W    = 17;
  // widest numerator count * 78125 * 2^(F-2), at the top of the fraction range
  localparam int NUM_W      = HP_W + DIV_W;

endpackage

`default_nettype wire

[src/swtg_in_if.sv]
// swtg_in_if: valid/ready channel carrying one tone command item.
// Depends on swtg_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface swtg_in_if;
  logic                             valid;
  logic                             ready;
  logic [swtg_pkg::CMD_W-1:0]       cmd;
  logic [swtg_pkg::COUNT_W-1:0]     tone_count;
  logic [swtg_pkg::AMP_W-1:0]       tone_amplitude;
  logic [swtg_pkg::DUR_W-1:0]       tone_duration;

  modport source (output valid, output cmd, output tone_count, output tone_amplitude,
                  output tone_duration, input ready);
  modport sink   (input valid, input cmd, input tone_count, input tone_amplitude,
                  input tone_duration, output ready);
endinterface

`default_nettype wire

[src/swtg_out_if.sv]
// swtg_out_if: valid/ready channel carrying one output sample item.
// Depends on swtg_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface swtg_out_if;
  logic                              valid;
  logic                              ready;
  logic [swtg_pkg::SAMPLE_W-1:0]     sample_value;
  logic                              tone_active;
  logic                              tone_last;

  modport source (output valid, output sample_value, output tone_active,
                  output tone_last, input ready);
  modport sink   (input valid, input sample_value, input tone_active,
                  input tone_last, output ready);
endinterface

`default_nettype wire

[src/square_wave_tone_generator_top.sv]
// square_wave_tone_generator_top: square-wave tone generator, load and tick items in,
// 8-bit samples out. Depends on swtg_pkg, swtg_in_if and swtg_out_if.
//
//   channel  | dir | handshake         | payload
//   in_ch    | in  | valid/ready       | cmd, tone_count, tone_amplitude, tone_duration
//   out_ch   | out | valid/ready       | sample_value, tone_active, tone_last
//
// one item accepted per cycle while in_ch.ready is high; a tick's sample passes the input
// register, two multiply stages, then the tone state update into the output register.
// loads give no item; their half-period is ready for the next tick.
// rst_n clears stage valids, the output valid and the playing flag.
// in_ch.ready drops only while a tick in the last stage faces a full, stalled
// output register; then the whole pipe holds.
`timescale 1ns / 1ps
`default_nettype none

module square_wave_tone_generator_top #(
  parameter int BUFFER_SAMPLES = swtg_pkg::BUFFER_SAMPLES_DEF,
  parameter int FRACTION_BITS  = swtg_pkg::FRACTION_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  swtg_in_if.sink     in_ch,
  swtg_out_if.source  out_ch
);

  localparam int POS_W    = (BUFFER_SAMPLES > 1) ? $clog2(BUFFER_SAMPLES) : 1;
  localparam int SCALE_SH = FRACTION_BITS - 2;
  localparam int RECIP_SH = swtg_pkg::COUNT_W;
  localparam int PROD_W   = swtg_pkg::COUNT_W + swtg_pkg::HP_W;
  localparam int NUM_W    = swtg_pkg::NUM_W;
  localparam int HP_W     = swtg_pkg::HP_W;
  localparam int SAMPLE_W = swtg_pkg::SAMPLE_W;
  localparam int DUR_W    = swtg_pkg::DUR_W;
  localparam int AMP_W    = swtg_pkg::AMP_W;
  localparam int COUNT_W  = swtg_pkg::COUNT_W;
  localparam int CMD_W    = swtg_pkg::CMD_W;
  localparam int EL_W     = swtg_pkg::ELAPSED_W;
  localparam int EDGE_W   = swtg_pkg::EDGE_W;

  // reciprocal estimate of the scale factor; low by at most one for any count
  localparam logic [63:0] RECIP_FULL =
    (64'(swtg_pkg::SCALE_CORE) << (SCALE_SH + RECIP_SH)) / 64'(swtg_pkg::DIV_CORE);
  localparam logic [HP_W-1:0]  RECIP   = RECIP_FULL[HP_W-1:0];
  localparam logic [NUM_W-1:0] DIV_N   = NUM_W'(swtg_pkg::DIV_CORE);
  localparam logic [NUM_W-1:0] SCALE_N = NUM_W'(swtg_pkg::SCALE_CORE);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(BUFFER_SAMPLES - 1);

  // stage 1: input register
  logic                v1_r;
  logic [CMD_W-1:0]    cmd1_r;
  logic [COUNT_W-1:0]  cnt1_r;
  logic [AMP_W-1:0]    amp1_r;
  logic [DUR_W-1:0]    dur1_r;

  // stage 2: reciprocal product and exact numerator
  logic                v2_r;
  logic [CMD_W-1:0]    cmd2_r;
  logic [AMP_W-1:0]    amp2_r;
  logic [DUR_W-1:0]    dur2_r;
  logic                nz2_r;
  logic [PROD_W-1:0]   prod2_r, prod2_nxt;
  logic [NUM_W-1:0]    ck2_r, ck2_nxt;
  logic [COUNT_W-1:0]  cnt_clamp;

  // stage 3: quotient estimate and its back-product
  logic                v3_r;
  logic [CMD_W-1:0]    cmd3_r;
  logic [AMP_W-1:0]    amp3_r;
  logic [DUR_W-1:0]    dur3_r;
  logic                nz3_r;
  logic [HP_W-1:0]     qe3_r, qe3_nxt;
  logic [NUM_W-1:0]    t3_r, t3_nxt;
  logic [NUM_W-1:0]    ck3_r;

  // tone state
  logic [SAMPLE_W-1:0] level_r, level_nxt;
  logic [HP_W-1:0]     half_period_r, half_period_nxt;
  logic [EL_W-1:0]     elapsed_r, elapsed_nxt;
  logic [EDGE_W-1:0]   next_edge_r, next_edge_nxt;
  logic [DUR_W-1:0]    buffers_left_r, buffers_left_nxt;
  logic [POS_W-1:0]    buf_pos_r, buf_pos_nxt;
  logic                playing_r, playing_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;
  logic                out_active_r, out_active_nxt;
  logic                out_last_r, out_last_nxt;

  logic                stall;
  logic                adv;
  logic                take;
  logic [NUM_W-1:0]    rem;
  logic [HP_W-1:0]     half_calc;
  logic                edge_hit;
  logic [SAMPLE_W-1:0] level_tick;
  logic [DUR_W-1:0]    buffers_dec;

  assign stall = v3_r && (cmd3_r == swtg_pkg::CMD_TICK) && out_valid_r && !out_ch.ready;
  assign adv   = !stall;
  assign take  = v3_r && adv;

  assign in_ch.ready         = adv;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.sample_value = out_sample_r;
  assign out_ch.tone_active  = out_active_r;
  assign out_ch.tone_last    = out_last_r;

  // short counts are raised to the minimum, zero stays zero
  always_comb begin
    cnt_clamp = cnt1_r;
    if ((cnt1_r != '0) && (cnt1_r < swtg_pkg::MIN_COUNT)) begin
      cnt_clamp = swtg_pkg::MIN_COUNT;
    end
    prod2_nxt = PROD_W'(cnt_clamp) * PROD_W'(RECIP);
    ck2_nxt   = (NUM_W'(cnt_clamp) * SCALE_N) << SCALE_SH;
  end

  assign qe3_nxt = prod2_r[RECIP_SH +: HP_W];
  assign t3_nxt  = NUM_W'(qe3_nxt) * DIV_N;

  // remainder below twice the divisor, so one correction step
  assign rem       = ck3_r - t3_r;
  assign half_calc = qe3_r + HP_W'(rem >= DIV_N);

  assign edge_hit    = next_edge_r[FRACTION_BITS +: EL_W] == elapsed_r;
  assign buffers_dec = buffers_left_r - DUR_W'(1);

  always_comb begin
    level_nxt        = level_r;
    half_period_nxt  = half_period_r;
    elapsed_nxt      = elapsed_r;
    next_edge_nxt    = next_edge_r;
    buffers_left_nxt = buffers_left_r;
    buf_pos_nxt      = buf_pos_r;
    playing_nxt      = playing_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    out_sample_nxt   = out_sample_r;
    out_active_nxt   = out_active_r;
    out_last_nxt     = out_last_r;
    level_tick       = level_r;

    if (take && (cmd3_r == swtg_pkg::CMD_LOAD)) begin
      half_period_nxt  = half_calc;
      level_nxt        = swtg_pkg::MIDPOINT - SAMPLE_W'(amp3_r >> 1);
      elapsed_nxt      = '0;
      next_edge_nxt    = '0;
      buffers_left_nxt = dur3_r;
      buf_pos_nxt      = '0;
      playing_nxt      = nz3_r && (dur3_r != '0);
    end else if (take) begin
      out_valid_nxt = 1'b1;
      if (!playing_r) begin
        out_sample_nxt = swtg_pkg::MIDPOINT;
        out_active_nxt = 1'b0;
        out_last_nxt   = 1'b0;
      end else begin
        if (edge_hit) begin
          // first sample of a buffer moves the edge but keeps the level
          if (buf_pos_r != '0) begin
            level_tick = SAMPLE_W'(0) - level_r;
          end
          next_edge_nxt = next_edge_r + EDGE_W'(half_period_r);
        end
        level_nxt      = level_tick;
        out_sample_nxt = level_tick;
        out_active_nxt = 1'b1;
        out_last_nxt   = 1'b0;
        elapsed_nxt    = elapsed_r + EL_W'(1);
        if (buf_pos_r == POS_LAST) begin
          buf_pos_nxt      = '0;
          buffers_left_nxt = buffers_dec;
          if (buffers_dec == '0) begin
            playing_nxt  = 1'b0;
            out_last_nxt = 1'b1;
          end
        end else begin
          buf_pos_nxt = buf_pos_r + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      playing_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        v1_r <= in_ch.valid;
        v2_r <= v1_r;
        v3_r <= v2_r;
      end
      playing_r   <= playing_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd1_r  <= in_ch.cmd;
      cnt1_r  <= in_ch.tone_count;
      amp1_r  <= in_ch.tone_amplitude;
      dur1_r  <= in_ch.tone_duration;

      cmd2_r  <= cmd1_r;
      amp2_r  <= amp1_r;
      dur2_r  <= dur1_r;
      nz2_r   <= cnt1_r != '0;
      prod2_r <= prod2_nxt;
      ck2_r   <= ck2_nxt;

      cmd3_r  <= cmd2_r;
      amp3_r  <= amp2_r;
      dur3_r  <= dur2_r;
      nz3_r   <= nz2_r;
      qe3_r   <= qe3_nxt;
      t3_r    <= t3_nxt;
      ck3_r   <= ck2_r;
    end
    level_r        <= level_nxt;
    half_period_r  <= half_period_nxt;
    elapsed_r      <= elapsed_nxt;
    next_edge_r    <= next_edge_nxt;
    buffers_left_r <= buffers_left_nxt;
    buf_pos_r      <= buf_pos_nxt;
    out_sample_r   <= out_sample_nxt;
    out_active_r   <= out_active_nxt;
    out_last_r     <= out_last_nxt;
  end

endmodule

`default_nettype wire

[tb/sv/swtg_sample_checker.sv]
// swtg_sample_checker: watches the tone command and sample channels, predicts every
// sample from its own copy of the tone state and compares field by field.
// Depends on swtg_pkg, swtg_in_if and swtg_out_if.
`timescale 1ns / 1ps

module swtg_sample_checker #(
  parameter int BUFFER_SAMPLES = swtg_pkg::BUFFER_SAMPLES_DEF,
  parameter int FRACTION_BITS  = swtg_pkg::FRACTION_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  swtg_in_if   in_ch,
  swtg_out_if  out_ch,
  output int   mismatches,
  output int   pending,
  output int   samples_checked,
  output int   tone_ends
);
  import swtg_pkg::*;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                active;
    logic                last;
  } sample_t;

  // 4493 * 78336 scaled against 10^7 ns
  localparam longint unsigned SAMPLE_DIV = 64'd4493 * 64'd78336;
  localparam longint unsigned NS_PER_10MS = 64'd10000000;

  sample_t expected_samples[$];
  sample_t got, want, predicted;

  logic [SAMPLE_W-1:0]  level_q;
  logic [HP_W-1:0]      half_period_q;
  logic [ELAPSED_W-1:0] elapsed_q;
  logic [EDGE_W-1:0]    next_edge_q;
  logic [DUR_W-1:0]     buffers_left_q;
  int unsigned          buffer_pos_q;
  logic                 playing_q;

  int n_mismatch = 0;
  int n_checked  = 0;
  int n_ends     = 0;

  function automatic logic [HP_W-1:0] half_period_of(logic [COUNT_W-1:0] count);
    longint unsigned c;
    c = count;
    if (c != 0 && c < MIN_COUNT) c = MIN_COUNT;
    return HP_W'(((c << FRACTION_BITS) * NS_PER_10MS) / SAMPLE_DIV);
  endfunction

  task automatic report(string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    n_mismatch++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      level_q        = MIDPOINT;
      half_period_q  = '0;
      elapsed_q      = '0;
      next_edge_q    = '0;
      buffers_left_q = '0;
      buffer_pos_q   = 0;
      playing_q      = 1'b0;
      expected_samples.delete();
    end else begin
      // compare first so a tick taken this edge cannot hide an early sample
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.sample_value, out_ch.tone_active, out_ch.tone_last};
        if (expected_samples.size() == 0) begin
          report($sformatf("sample %0d active %0b last %0b with nothing expected",
                           got.value, got.active, got.last));
        end else begin
          want = expected_samples.pop_front();
          n_checked++;
          if (got.value !== want.value)
            report($sformatf("sample_value %0d expected %0d", got.value, want.value));
          if (got.active !== want.active)
            report($sformatf("tone_active %0b expected %0b", got.active, want.active));
          if (got.last !== want.last)
            report($sformatf("tone_last %0b expected %0b", got.last, want.last));
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.cmd == CMD_LOAD) begin
          half_period_q  = half_period_of(in_ch.tone_count);
          level_q        = MIDPOINT - (in_ch.tone_amplitude >> 1);
          elapsed_q      = '0;
          next_edge_q    = '0;
          buffers_left_q = in_ch.tone_duration;
          buffer_pos_q   = 0;
          playing_q      = (in_ch.tone_count != 0) && (in_ch.tone_duration != 0);
        end else if (!playing_q) begin
          expected_samples.push_back('{MIDPOINT, 1'b0, 1'b0});
        end else begin
          if (ELAPSED_W'(next_edge_q >> FRACTION_BITS) == elapsed_q) begin
            // first sample of a buffer moves the edge on but keeps the level
            if (buffer_pos_q != 0) level_q = SAMPLE_W'(16'd256 - 16'(level_q));
            next_edge_q = next_edge_q + EDGE_W'(half_period_q);
          end
          predicted = '{level_q, 1'b1, 1'b0};
          elapsed_q = elapsed_q + 1'b1;
          buffer_pos_q++;
          if (buffer_pos_q >= BUFFER_SAMPLES) begin
            buffer_pos_q   = 0;
            buffers_left_q = buffers_left_q - 1'b1;
            if (buffers_left_q == 0) begin
              playing_q      = 1'b0;
              predicted.last = 1'b1;
              n_ends++;
            end
          end
          expected_samples.push_back(predicted);
        end
      end
    end
    mismatches      <= n_mismatch;
    pending         <= expected_samples.size();
    samples_checked <= n_checked;
    tone_ends       <= n_ends;
  end

endmodule

[tb/sv/tb_square_wave_tone_generator_top.sv]
// tb_square_wave_tone_generator_top: drives load and tick items with random gaps and
// back-pressure into the tone generator; swtg_sample_checker does the comparing.
// Depends on swtg_pkg, swtg_in_if, swtg_out_if, swtg_sample_checker and the block.
`timescale 1ns / 1ps

module tb_square_wave_tone_generator_top;
  import swtg_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD   = 200;
  localparam int TONE_SEQS   = 8;
  localparam int DRAIN_WAIT  = 12;

  typedef enum {SEQ_NOISE, SEQ_END_MARK, SEQ_EMPTY, SEQ_TONE} seq_kind_t;

  logic clk = 1'b0;
  logic rst_n;

  swtg_in_if  in_ch();
  swtg_out_if out_ch();

  int mismatches, pending, samples_checked, tone_ends;

  int unsigned cycle_count = 0;
  int          items_sent  = 0;
  int          loads_sent  = 0;
  int          holds_asked = 0;
  int          holds_done  = 0;
  logic        tx_steady   = 1'b0;
  logic        rx_steady   = 1'b0;
  int          rx_gap;

  seq_kind_t        kind;
  int               pick;
  logic [COUNT_W-1:0] tone_cnt;
  logic [DUR_W-1:0]   tone_dur;

  always #4 clk = ~clk;

  square_wave_tone_generator_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  swtg_sample_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .mismatches      (mismatches),
    .pending         (pending),
    .samples_checked (samples_checked),
    .tone_ends       (tone_ends)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d samples still owed", cycle_count, pending);
      $display("TB_ERROR");
      $finish;
    end
  end

  // offer one item after a random gap, return at the edge that takes it
  task automatic offer(input logic [CMD_W-1:0] cmd, input logic [COUNT_W-1:0] count,
                       input logic [AMP_W-1:0] amp, input logic [DUR_W-1:0] dur);
    int gap;
    if ($urandom_range(0, 29) == 0) tx_steady = ~tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.cmd            <= cmd;
    in_ch.tone_count     <= count;
    in_ch.tone_amplitude <= amp;
    in_ch.tone_duration  <= dur;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    if (cmd == CMD_LOAD) loads_sent++;
  endtask

  // tick fields are don't-care, so fill them with noise
  task automatic ticks(input int n);
    repeat (n) offer(CMD_TICK, COUNT_W'($urandom), AMP_W'($urandom), DUR_W'($urandom));
  endtask

  // sink side: random stalls, steady stretches, and one long hold on request
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (holds_asked != holds_done) begin
        holds_done++;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if ($urandom_range(0, 29) == 0) rx_steady = ~rx_steady;
      rx_gap = rx_steady ? 0 : $urandom_range(0, 9);
      if (rx_gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (rx_gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  initial begin
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.cmd            <= CMD_LOAD;
    in_ch.tone_count     <= '0;
    in_ch.tone_amplitude <= '0;
    in_ch.tone_duration  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle tick, end marker, empty tone, short counts raised,
    // reload mid-tone, widest fields, amplitude extremes
    ticks(1);
    offer(CMD_LOAD, '0, 8'd255, 16'd5);
    ticks(1);
    offer(CMD_LOAD, 16'd1000, 8'd100, '0);
    ticks(1);
    offer(CMD_LOAD, 16'd1, 8'd255, 16'd1);
    ticks(3);
    offer(CMD_LOAD, 16'd35, 8'd0, 16'd1);
    ticks(2);
    offer(CMD_LOAD, 16'hFFFF, 8'd254, 16'hFFFF);
    ticks(2);
    offer(CMD_LOAD, MIN_COUNT, 8'd1, 16'd1);
    ticks(3);
    offer(CMD_LOAD, 16'd37, 8'd255, 16'd2);
    ticks(2);

    for (int s = 0; s < TONE_SEQS; s++) begin
      pick = $urandom_range(0, 9);
      if (s == 0 || pick > 2) kind = SEQ_TONE;
      else if (pick == 0)     kind = SEQ_NOISE;
      else if (pick == 1)     kind = SEQ_END_MARK;
      else                    kind = SEQ_EMPTY;
      // one long sink hold while ticks keep coming, so the pipe backs up
      if (s == 0) holds_asked++;
      case (kind)
        SEQ_NOISE: begin
          repeat ($urandom_range(1, 8))
            offer(CMD_W'($urandom), COUNT_W'($urandom), AMP_W'($urandom), DUR_W'($urandom));
          ticks($urandom_range(1, 6));
        end
        SEQ_END_MARK: begin
          offer(CMD_LOAD, '0, AMP_W'($urandom), DUR_W'($urandom));
          ticks($urandom_range(1, 6));
        end
        SEQ_EMPTY: begin
          offer(CMD_LOAD, COUNT_W'($urandom_range(1, 65535)), AMP_W'($urandom), '0);
          ticks($urandom_range(1, 6));
        end
        default: begin
          case ($urandom_range(0, 2))
            0:       tone_cnt = COUNT_W'($urandom_range(1, 300));
            1:       tone_cnt = COUNT_W'($urandom_range(300, 4000));
            default: tone_cnt = COUNT_W'($urandom_range(1, 65535));
          endcase
          pick = $urandom_range(0, 19);
          if (s == 0 || pick < 14) tone_dur = 16'd1;
          else if (pick < 17)      tone_dur = 16'd2;
          else                     tone_dur = DUR_W'($urandom_range(3, 65535));
          offer(CMD_LOAD, tone_cnt, AMP_W'($urandom), tone_dur);
          // the first tone plays to its end and up to five ticks past, the rest are cut off early
          if (s == 0)
            ticks(BUFFER_SAMPLES_DEF + int'($urandom_range(0, 5)));
          else
            ticks($urandom_range(1, 10));
        end
      endcase
    end

    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("run covered %0d items (%0d tone loads) over %0d cycles", items_sent,
             loads_sent, cycle_count);
    $display("%0d samples compared, %0d tones played to their last sample", samples_checked,
             tone_ends);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
